// File: design/detector_pixel_window_labeler_macros.svh
// assertion helpers used by the checker file
`ifndef DETECTOR_PIXEL_WINDOW_LABELER_MACROS_SVH
`define DETECTOR_PIXEL_WINDOW_LABELER_MACROS_SVH

// same-cycle implication
`define DPWL_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpwl assertion failed");

// next-cycle implication
`define DPWL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpwl assertion failed");

`endif

// File: design/dpwl_pkg.sv
package dpwl_pkg;

   localparam int ADC_WIDTH      = 16;
   localparam int THRESH_WIDTH   = 16;
   localparam int STATUS_WIDTH   = 16;
   localparam int CMP_WIDTH      = (ADC_WIDTH > THRESH_WIDTH) ? ADC_WIDTH : THRESH_WIDTH;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADC_THRESHOLD    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STATUS_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_USE_STATUS       = 2'd2;

   localparam logic signed [THRESH_WIDTH-1:0] ADC_THRESHOLD_RESET = 16'sd10;
   localparam logic [STATUS_WIDTH-1:0]        CHSTATUS_GOOD       = 16'd4;

   localparam logic [1:0] CLASS_BACKGROUND = 2'd0;
   localparam logic [1:0] CLASS_SIGNAL     = 2'd1;
   localparam logic [1:0] CLASS_POSITIVE   = 2'd2;
   localparam logic [1:0] CLASS_NEAR       = 2'd3;

   localparam int WINDOW_DEPTH = 4;
   localparam int ROWS_WIDTH   = 3;
   localparam logic [ROWS_WIDTH-1:0] ROWS_SATURATE = 3'd4;

   localparam int MAX_RESULTS   = 3;
   localparam int QUEUE_DEPTH   = 5;
   localparam int QCOUNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QCOUNT_WIDTH-1:0] ROOM_LIMIT = QCOUNT_WIDTH'(QUEUE_DEPTH - MAX_RESULTS);

   typedef logic signed [ADC_WIDTH-1:0] adc_type;

   typedef struct packed {
      logic [1:0] class_label;
      logic       dead_label;
      adc_type    masked_adc;
      adc_type    raw_adc;
      logic       last_of_column;
   } dpwl_result_type;

   typedef struct packed {
      logic [1:0]                        count;
      dpwl_result_type [MAX_RESULTS-1:0] item;
   } dpwl_push_type;

   typedef struct packed {
      logic head_valid;
      logic has_room;
   } dpwl_queue_status_type;

   function automatic logic is_positive(input adc_type value);
      return !value[ADC_WIDTH-1] && (value != '0);
   endfunction

   function automatic dpwl_result_type make_result(
      input adc_type                        pix,
      input logic signed [THRESH_WIDTH-1:0] thresh,
      input logic                           near,
      input logic                           dead,
      input logic                           last
   );
      dpwl_result_type r;
      logic signed [CMP_WIDTH-1:0] pix_ext;
      logic signed [CMP_WIDTH-1:0] thr_ext;
      pix_ext = CMP_WIDTH'(pix);
      thr_ext = CMP_WIDTH'(thresh);
      if (pix_ext >= thr_ext) begin
         r.class_label = CLASS_SIGNAL;
      end else if (is_positive(pix)) begin
         r.class_label = CLASS_POSITIVE;
      end else if (near) begin
         r.class_label = CLASS_NEAR;
      end else begin
         r.class_label = CLASS_BACKGROUND;
      end
      r.dead_label     = dead;
      r.masked_adc     = dead ? '0 : pix;
      r.raw_adc        = pix;
      r.last_of_column = last;
      return r;
   endfunction

endpackage

// File: design/dpwl_stream_if.sv
interface dpwl_req_if;
   import dpwl_pkg::*;
   logic    valid;
   logic    ready;
   adc_type adc_sample;
   logic [STATUS_WIDTH-1:0] channel_status;
   logic    forced_dead;
   logic    column_end;

   modport source (output valid, adc_sample, channel_status, forced_dead, column_end,
                   input ready);
   modport sink   (input valid, adc_sample, channel_status, forced_dead, column_end,
                   output ready);
endinterface

interface dpwl_rsp_if;
   import dpwl_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] class_label;
   logic       dead_label;
   adc_type    masked_adc;
   adc_type    raw_adc;
   logic       last_of_column;

   modport source (output valid, class_label, dead_label, masked_adc, raw_adc, last_of_column,
                   input ready);
   modport sink   (input valid, class_label, dead_label, masked_adc, raw_adc, last_of_column,
                   output ready);
endinterface

// File: design/dpwl_result_queue.sv
module dpwl_result_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  dpwl_pkg::dpwl_push_type        push,
   input  logic                           pop,
   output dpwl_pkg::dpwl_result_type      head,
   output dpwl_pkg::dpwl_queue_status_type status
);
   import dpwl_pkg::*;

   dpwl_result_type entries_ff [QUEUE_DEPTH];
   dpwl_result_type entries_in [QUEUE_DEPTH];
   dpwl_result_type shifted    [QUEUE_DEPTH];
   logic [QCOUNT_WIDTH-1:0] count_ff;
   logic [QCOUNT_WIDTH-1:0] count_in;
   logic [QCOUNT_WIDTH-1:0] base;

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         shifted[i] = pop ? entries_ff[i+1] : entries_ff[i];
      end
      shifted[QUEUE_DEPTH-1] = entries_ff[QUEUE_DEPTH-1];
   end

   // entries kept after the pop move down, new results land right behind them
   always_comb begin
      base = count_ff - QCOUNT_WIDTH'(pop);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         logic [QCOUNT_WIDTH-1:0] offset;
         offset = QCOUNT_WIDTH'(i) - base;
         if (QCOUNT_WIDTH'(i) < base) begin
            entries_in[i] = shifted[i];
         end else if (offset < QCOUNT_WIDTH'(push.count)) begin
            entries_in[i] = push.item[offset[1:0]];
         end else begin
            entries_in[i] = entries_ff[i];
         end
      end
      count_in = base + QCOUNT_WIDTH'(push.count);
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head              = entries_ff[0];
   assign status.head_valid = (count_ff != '0);
   assign status.has_room   = (count_ff <= ROOM_LIMIT);

endmodule

// File: design/detector_pixel_window_labeler.sv
// channel   | dir | handshake        | payload
// req_bus   | in  | valid / ready    | adc_sample, channel_status, forced_dead, column_end
// rsp_bus   | out | valid / ready    | class_label, dead_label, masked_adc, raw_adc,
//           |     |                  | last_of_column
// csr_*     | in  | csr_write_enable | csr_index, csr_write_data
//
// one request per cycle while req ready is high; each request is labeled in the cycle it is taken and its
// results (zero, one, or up to three on a column end) enter a five-entry result queue
// results leave one per cycle while rsp ready is high;
// req ready is high while the queue holds two results or fewer
// reset is synchronous: window, row count, dead flag, queue and registers go to reset values
// rsp stalls back up through the queue to req ready; no request or result is dropped
module detector_pixel_window_labeler (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [dpwl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [dpwl_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   dpwl_req_if.sink                              req_bus,
   dpwl_rsp_if.source                            rsp_bus
);
   import dpwl_pkg::*;

   logic signed [THRESH_WIDTH-1:0] adc_threshold_ff;
   logic [STATUS_WIDTH-1:0]        status_threshold_ff;
   logic                           use_status_ff;

   adc_type                 window_ff [WINDOW_DEPTH];
   adc_type                 window_in [WINDOW_DEPTH];
   logic [ROWS_WIDTH-1:0]   rows_seen_ff;
   logic [ROWS_WIDTH-1:0]   rows_seen_in;
   logic                    column_dead_ff;
   logic                    column_dead_in;

   dpwl_push_type           push;
   dpwl_result_type         head;
   dpwl_queue_status_type   queue_status;
   logic                    accept;
   logic                    pop;

   adc_type cur;
   logic    dead;
   logic    has_a;
   logic    has_b;
   logic    near_a;
   logic    near_b;
   logic    near_c;
   dpwl_result_type res_a;
   dpwl_result_type res_b;
   dpwl_result_type res_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         adc_threshold_ff    <= ADC_THRESHOLD_RESET;
         status_threshold_ff <= CHSTATUS_GOOD;
         use_status_ff       <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ADC_THRESHOLD:    adc_threshold_ff    <= THRESH_WIDTH'(csr_write_data);
            CSR_STATUS_THRESHOLD: status_threshold_ff <= STATUS_WIDTH'(csr_write_data);
            CSR_USE_STATUS:       use_status_ff       <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign accept = req_bus.valid && queue_status.has_room;
   assign cur    = req_bus.adc_sample;

   always_comb begin
      // dead decision comes from the first sample of the column
      if (rows_seen_ff == '0) begin
         dead = req_bus.forced_dead ||
                (use_status_ff && (req_bus.channel_status < status_threshold_ff));
      end else begin
         dead = column_dead_ff;
      end

      has_a = (rows_seen_ff >= 3'd2);
      has_b = req_bus.column_end && (rows_seen_ff >= 3'd1);

      // only rows that exist in the column count as neighbors
      near_a = is_positive(window_ff[0]) || is_positive(cur) || is_positive(window_ff[2]) ||
               ((rows_seen_ff >= ROWS_SATURATE) && is_positive(window_ff[3]));
      near_b = is_positive(cur) ||
               ((rows_seen_ff >= 3'd2) && is_positive(window_ff[1])) ||
               ((rows_seen_ff >= 3'd3) && is_positive(window_ff[2]));
      near_c = ((rows_seen_ff >= 3'd1) && is_positive(window_ff[0])) ||
               ((rows_seen_ff >= 3'd2) && is_positive(window_ff[1]));

      res_a = make_result(window_ff[1], adc_threshold_ff, near_a, dead, 1'b0);
      res_b = make_result(window_ff[0], adc_threshold_ff, near_b, dead, 1'b0);
      res_c = make_result(cur,          adc_threshold_ff, near_c, dead, 1'b1);

      // results packed oldest pixel first
      push.item[0] = has_a ? res_a : (has_b ? res_b : res_c);
      push.item[1] = has_a ? res_b : res_c;
      push.item[2] = res_c;
      if (accept) begin
         push.count = 2'(has_a) + 2'(has_b) + 2'(req_bus.column_end);
      end else begin
         push.count = 2'd0;
      end

      column_dead_in = dead;
      if (req_bus.column_end) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_in[i] = '0;
         end
         rows_seen_in = '0;
      end else begin
         window_in[0] = cur;
         for (int i = 1; i < WINDOW_DEPTH; i++) begin
            window_in[i] = window_ff[i-1];
         end
         rows_seen_in = (rows_seen_ff < ROWS_SATURATE) ? rows_seen_ff + 3'd1 : rows_seen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
         rows_seen_ff   <= '0;
         column_dead_ff <= 1'b0;
      end else if (accept) begin
         window_ff      <= window_in;
         rows_seen_ff   <= rows_seen_in;
         column_dead_ff <= column_dead_in;
      end
   end

   assign pop = queue_status.head_valid && rsp_bus.ready;

   dpwl_result_queue u_result_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (queue_status)
   );

   assign req_bus.ready          = queue_status.has_room;
   assign rsp_bus.valid          = queue_status.head_valid;
   assign rsp_bus.class_label    = head.class_label;
   assign rsp_bus.dead_label     = head.dead_label;
   assign rsp_bus.masked_adc     = head.masked_adc;
   assign rsp_bus.raw_adc        = head.raw_adc;
   assign rsp_bus.last_of_column = head.last_of_column;

endmodule

// File: design/dpwl_checker.sv
`include "detector_pixel_window_labeler_macros.svh"

module dpwl_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [1:0]          class_label,
   input logic                dead_label,
   input dpwl_pkg::adc_type   masked_adc,
   input dpwl_pkg::adc_type   raw_adc,
   input logic                last_of_column
);
   import dpwl_pkg::*;

   logic            rsp_stall;
   dpwl_result_type rsp_payload;
   logic            mask_ok;
   logic            raw_positive;
   logic            rsp_positive;
   logic            rsp_near;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_payload  = {class_label, dead_label, masked_adc, raw_adc, last_of_column};
   assign mask_ok      = dead_label ? (masked_adc == '0) : (masked_adc == raw_adc);
   assign raw_positive = !raw_adc[ADC_WIDTH-1] && (raw_adc != '0);
   assign rsp_positive = rsp_valid && (class_label == CLASS_POSITIVE);
   assign rsp_near     = rsp_valid && (class_label == CLASS_NEAR);

   // a stalled result on the response side keeps its payload
   `DPWL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   `DPWL_ASSERT_IMPLIES(a_mask, clock, reset, rsp_valid, mask_ok)

   `DPWL_ASSERT_IMPLIES(a_positive, clock, reset, rsp_positive, raw_positive)

   `DPWL_ASSERT_IMPLIES(a_near, clock, reset, rsp_near, !raw_positive)

endmodule

bind detector_pixel_window_labeler dpwl_checker u_dpwl_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .class_label    (rsp_bus.class_label),
   .dead_label     (rsp_bus.dead_label),
   .masked_adc     (rsp_bus.masked_adc),
   .raw_adc        (rsp_bus.raw_adc),
   .last_of_column (rsp_bus.last_of_column)
);
